FILE: rtl/sjpq_pkg.sv
// Package: shared types, sizes and codes of the shortest-job priority queue.
package sjpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 16;
    localparam int TAG_W       = 8;
    localparam int OCC_W       = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] burst_time;
        logic [TAG_W-1:0] job_tag;
    } t_in_item;

    typedef struct packed {
        logic             out_valid;
        logic [TAG_W-1:0] out_tag;
        logic [KEY_W-1:0] out_burst;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    // contents of one cell
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_slot;

    // command broadcast to every cell
    typedef struct packed {
        logic             insert;
        logic             pop;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_cmd;

endpackage

FILE: rtl/sjpq_if.sv
// Interfaces: valid/ready channels for input items and result items.
interface sjpq_in_if;
    logic              valid;
    logic              ready;
    sjpq_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sjpq_out_if;
    logic               valid;
    logic               ready;
    sjpq_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sjpq_cell.sv
// Queue cell: holds one job, compares against the insert key, shifts with neighbors.
module sjpq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sjpq_pkg::t_cmd  i_cmd,
    input  sjpq_pkg::t_slot i_prev,
    input  logic            i_prev_gt,
    input  sjpq_pkg::t_slot i_next,
    output sjpq_pkg::t_slot o_slot,
    output logic            o_gt
);

    sjpq_pkg::t_slot r_slot;
    sjpq_pkg::t_slot n_slot;

    // empty cells count as holding a larger key
    assign o_gt   = !r_slot.valid || (r_slot.key > i_cmd.key);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.pop) begin
            n_slot = i_next;
        end else if (i_cmd.insert) begin
            if (i_prev_gt) begin
                n_slot = i_prev;
            end else if (o_gt) begin
                n_slot.valid = 1'b1;
                n_slot.key   = i_cmd.key;
                n_slot.tag   = i_cmd.tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.key <= n_slot.key;
        r_slot.tag <= n_slot.tag;
    end

endmodule

FILE: rtl/shortest_job_priority_queue_top.sv
// Top level: shortest-job-first queue built as a sorted chain of cells.
// A result is written into the output register when its item is accepted.
// Throughput: one item per cycle while results are drained; every cell compares and shifts in parallel.
// An input item is taken whenever the output register is empty or being drained.
// Reset (synchronous, active low) clears cell valid bits, fill count and output valid;
// stored keys and tags stay undefined until written.
module shortest_job_priority_queue_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sjpq_in_if.sink           i_in,
    sjpq_out_if.source        o_out
);

    localparam int D = sjpq_pkg::QUEUE_DEPTH;

    sjpq_pkg::t_slot w_slot [D];
    sjpq_pkg::t_slot w_prev [D];
    sjpq_pkg::t_slot w_next [D];
    logic            w_gt   [D];
    logic            w_pgt  [D];
    logic [D-1:0]    w_valid;

    sjpq_pkg::t_cmd             w_cmd;
    logic [sjpq_pkg::CNT_W-1:0] r_count;
    logic [sjpq_pkg::CNT_W-1:0] n_count;
    sjpq_pkg::t_out_item        r_out;
    sjpq_pkg::t_out_item        n_out;
    logic                       r_out_valid;
    logic                       w_accept;
    logic                       w_full;
    logic                       w_empty;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == sjpq_pkg::CNT_W'(D));
    assign w_empty    = !w_slot[0].valid;

    assign w_cmd.insert = w_accept && (i_in.data.action == sjpq_pkg::ACT_INSERT) && !w_full;
    assign w_cmd.pop    = w_accept && (i_in.data.action == sjpq_pkg::ACT_POP) && !w_empty;
    assign w_cmd.key    = i_in.data.burst_time;
    assign w_cmd.tag    = i_in.data.job_tag;

    for (genvar i = 0; i < D; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign w_prev[i] = '0;
            assign w_pgt[i]  = 1'b0;
        end else begin : g_body
            assign w_prev[i] = w_slot[i-1];
            assign w_pgt[i]  = w_gt[i-1];
        end
        if (i == D - 1) begin : g_tail
            assign w_next[i] = '0;
        end else begin : g_mid
            assign w_next[i] = w_slot[i+1];
        end
        assign w_valid[i] = w_slot[i].valid;

        sjpq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_prev    (w_prev[i]),
            .i_prev_gt (w_pgt[i]),
            .i_next    (w_next[i]),
            .o_slot    (w_slot[i]),
            .o_gt      (w_gt[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.insert) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.pop) begin
            n_count = r_count - 1'b1;
        end

        n_out           = '0;
        n_out.status    = sjpq_pkg::ST_OK;
        n_out.occupancy = sjpq_pkg::OCC_W'(n_count);
        if (i_in.data.action == sjpq_pkg::ACT_INSERT) begin
            if (w_full) begin
                n_out.status = sjpq_pkg::ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_out.status = sjpq_pkg::ST_EMPTY;
            end else begin
                n_out.out_valid = 1'b1;
                n_out.out_tag   = w_slot[0].tag;
                n_out.out_burst = w_slot[0].key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTH
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("fill count differs from valid cells");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not decrement count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && i_in.data.action == sjpq_pkg::ACT_INSERT) |=> $stable(r_count))
        else $error("full insert changed the queue");

    for (genvar j = 0; j < D - 1; j++) begin : g_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_slot[j+1].valid |-> (w_slot[j].valid && w_slot[j].key <= w_slot[j+1].key))
            else $error("cell chain out of order");
    end
`endif

endmodule

FILE: tb/shortest_job_priority_queue_top_test.sv
// Testbench: random and directed insert/pop traffic against a shortest-job-first queue predictor.
module shortest_job_priority_queue_top_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_PCT     = 13;
    localparam int CALM_FIRST   = 250;
    localparam int CALM_LAST    = 400;
    localparam int HOLD_AT      = 450;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_REPORTS  = 60;

    class sjf_order_board;
        logic [sjpq_pkg::KEY_W-1:0] queued_bursts[sjpq_pkg::QUEUE_DEPTH];
        logic [sjpq_pkg::TAG_W-1:0] queued_tags[sjpq_pkg::QUEUE_DEPTH];
        int                         queued_jobs;
        sjpq_pkg::t_out_item        due_results[$];
        int                         error_count;

        function new();
            queued_jobs = 0;
            error_count = 0;
        endfunction

        function void flag_error(string what, longint unsigned want, longint unsigned got);
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        endfunction

        // accepted input item: update the sorted queue and record the result it owes
        function void note_item(sjpq_pkg::t_in_item item);
            sjpq_pkg::t_out_item res;
            int                  slot;
            res = '0;
            res.status = sjpq_pkg::ST_OK;
            if (item.action == sjpq_pkg::ACT_INSERT) begin
                if (queued_jobs >= sjpq_pkg::QUEUE_DEPTH) begin
                    res.status = sjpq_pkg::ST_FULL;
                end else begin
                    slot = queued_jobs;
                    for (int i = 0; i < queued_jobs; i++) begin
                        if (slot == queued_jobs && queued_bursts[i] > item.burst_time)
                            slot = i;
                    end
                    for (int i = queued_jobs; i > slot; i--) begin
                        queued_bursts[i] = queued_bursts[i-1];
                        queued_tags[i]   = queued_tags[i-1];
                    end
                    queued_bursts[slot] = item.burst_time;
                    queued_tags[slot]   = item.job_tag;
                    queued_jobs++;
                end
            end else if (queued_jobs == 0) begin
                res.status = sjpq_pkg::ST_EMPTY;
            end else begin
                res.out_valid = 1'b1;
                res.out_tag   = queued_tags[0];
                res.out_burst = queued_bursts[0];
                for (int i = 0; i + 1 < queued_jobs; i++) begin
                    queued_bursts[i] = queued_bursts[i+1];
                    queued_tags[i]   = queued_tags[i+1];
                end
                queued_jobs--;
            end
            res.occupancy = sjpq_pkg::OCC_W'(queued_jobs);
            due_results.push_back(res);
        endfunction

        function void check_result(sjpq_pkg::t_out_item got);
            sjpq_pkg::t_out_item want;
            if (due_results.size() == 0) begin
                flag_error("unexpected result item", 0, got);
                return;
            end
            want = due_results.pop_front();
            if (got.out_valid !== want.out_valid)
                flag_error("out_valid", want.out_valid, got.out_valid);
            if (got.out_tag !== want.out_tag)
                flag_error("out_tag", want.out_tag, got.out_tag);
            if (got.out_burst !== want.out_burst)
                flag_error("out_burst", want.out_burst, got.out_burst);
            if (got.status !== want.status)
                flag_error("status", want.status, got.status);
            if (got.occupancy !== want.occupancy)
                flag_error("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   jobs_sent;

    sjf_order_board board;

    sjpq_in_if  job_ch();
    sjpq_out_if res_ch();

    shortest_job_priority_queue_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (job_ch.sink),
        .o_out   (res_ch.source)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit calm_window();
        return jobs_sent >= CALM_FIRST && jobs_sent < CALM_LAST;
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_result(res_ch.data);
    end

    // result side: random stalls, a quiet stretch, and one long hold-off
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!held && jobs_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm_window() || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    task automatic offer_job(input logic action, input logic [sjpq_pkg::KEY_W-1:0] burst,
                             input logic [sjpq_pkg::TAG_W-1:0] tag);
        sjpq_pkg::t_in_item item;
        item.action     = action;
        item.burst_time = burst;
        item.job_tag    = tag;
        if (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
            job_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        job_ch.valid <= 1'b1;
        job_ch.data  <= item;
        @(posedge i_clk);
        while (!job_ch.ready) @(posedge i_clk);
        board.note_item(item);
        jobs_sent++;
    endtask

    task automatic run_random_traffic();
        int                         seg_left;
        int                         insert_pct;
        logic                       action;
        logic [sjpq_pkg::KEY_W-1:0] burst;
        seg_left   = 0;
        insert_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 3))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    2: insert_pct = 85;
                    default: insert_pct = 100;
                endcase
            end
            seg_left--;
            action = ($urandom_range(0, 99) < insert_pct) ? sjpq_pkg::ACT_INSERT
                                                          : sjpq_pkg::ACT_POP;
            // narrow keys often, so equal bursts pile up
            if ($urandom_range(0, 3) == 0)
                burst = sjpq_pkg::KEY_W'($urandom_range(0, 7));
            else
                burst = sjpq_pkg::KEY_W'($urandom_range(0, 65535));
            offer_job(action, burst, sjpq_pkg::TAG_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        board       = new();
        cycle_count = 0;
        jobs_sent   = 0;
        i_rst_n      <= 1'b0;
        job_ch.valid <= 1'b0;
        job_ch.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pop on empty, unused fields all ones
        offer_job(sjpq_pkg::ACT_POP, 16'hFFFF, 8'hFF);
        // fill to the top: extremes, ties at min, mid and max
        offer_job(sjpq_pkg::ACT_INSERT, 16'hFFFF, 8'hFF);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h0000, 8'h00);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h8000, 8'h01);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h8000, 8'h02);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h8000, 8'h03);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h0001, 8'h80);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h7FFF, 8'h7F);
        offer_job(sjpq_pkg::ACT_INSERT, 16'hFFFF, 8'hFE);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h0000, 8'h10);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h5555, 8'h55);
        offer_job(sjpq_pkg::ACT_INSERT, 16'hAAAA, 8'hAA);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h1234, 8'h34);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h00FF, 8'h0F);
        offer_job(sjpq_pkg::ACT_INSERT, 16'hFF00, 8'hF0);
        offer_job(sjpq_pkg::ACT_INSERT, 16'h0F0F, 8'hC3);
        offer_job(sjpq_pkg::ACT_INSERT, 16'hF0F0, 8'h3C);
        // full: dropped even though it has the shortest burst
        offer_job(sjpq_pkg::ACT_INSERT, 16'h0000, 8'h42);
        offer_job(sjpq_pkg::ACT_POP, 16'h0000, 8'h00);
        offer_job(sjpq_pkg::ACT_POP, 16'h0000, 8'h00);
        offer_job(sjpq_pkg::ACT_POP, 16'hFFFF, 8'hFF);

        run_random_traffic();
        job_ch.valid <= 1'b0;

        while (board.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (board.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: files.f
rtl/sjpq_pkg.sv
rtl/sjpq_if.sv
rtl/sjpq_cell.sv
rtl/shortest_job_priority_queue_top.sv
tb/shortest_job_priority_queue_top_test.sv
